// ===== sv/itoa_pkg.sv =====
// itoa_pkg: shared types, character codes and helpers for the int64 to ASCII formatter.
// Used by itoa_front, itoa_fifo, itoa_back and the top level; depends on nothing.
package itoa_pkg;

    localparam int VALUE_W       = 64;
    localparam int DEC_DIGITS    = 20;
    localparam int HEX_DIGITS    = 16;
    localparam int BCD_W         = DEC_DIGITS * 4;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_L     = 8'h6C;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               hex;
        logic               upper;
        logic               neg;
    } itoa_item_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== sv/itoa_front.sv =====
// itoa_front: accepts requests, forms the unsigned magnitude and sign, classifies radix/case.
// Depends on itoa_pkg.
module itoa_front (
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [63:0]              value,
    input  logic                            radix_hex,
    input  logic                            upper_case,
    input  logic                            q_full,
    output logic                            q_push,
    output itoa_pkg::itoa_item_t            q_item
);

    logic neg;

    assign neg      = value[63];
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.mag   = neg ? (64'd0 - 64'(value)) : 64'(value);
        q_item.hex   = radix_hex;
        q_item.upper = upper_case;
        q_item.neg   = neg;
    end

endmodule

// ===== sv/itoa_fifo.sv =====
// itoa_fifo: short request queue between front and back.
// Depends on itoa_pkg.
module itoa_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  itoa_pkg::itoa_item_t wr_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output itoa_pkg::itoa_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    itoa_pkg::itoa_item_t mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic do_push;
    logic do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/itoa_back.sv =====
// itoa_back: binary-to-BCD conversion for decimal (4 bits per cycle), digit count, character emission.
// Depends on itoa_pkg; holds the output register.
module itoa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  itoa_pkg::itoa_item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           character,
    output logic                 last
);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_COUNT, S_EMIT} state_t;
    typedef enum logic [2:0] {P_SIGN, P_ZERO, P_X, P_DIG, P_L1, P_L2} phase_t;

    localparam int STEP_W = $clog2(itoa_pkg::CONV_STEPS);
    localparam int IDX_W  = $clog2(itoa_pkg::DEC_DIGITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(itoa_pkg::CONV_STEPS - 1);

    state_t                        state_reg;
    phase_t                        phase_reg;
    itoa_pkg::itoa_item_t          item_reg;
    logic [itoa_pkg::VALUE_W-1:0]  shift_reg;
    logic [itoa_pkg::BCD_W-1:0]    bcd_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          out_valid_reg;
    logic [7:0]                    char_reg;
    logic                          last_reg;

    logic [itoa_pkg::BCD_W-1:0]    bcd_next;
    logic [itoa_pkg::VALUE_W-1:0]  shift_next;
    logic [IDX_W-1:0]              top_next;
    logic                          emit_ok;
    logic                          emit_fire;
    logic [3:0]                    cur_digit;

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign emit_ok   = !out_valid_reg || out_ready;
    assign emit_fire = (state_reg == S_EMIT) && emit_ok;
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    // shift-add-3, four bits per cycle
    always_comb
    begin
        bcd_next   = bcd_reg;
        shift_next = shift_reg;
        for (int k = 0; k < itoa_pkg::BITS_PER_STEP; k++)
        begin
            for (int j = 0; j < itoa_pkg::DEC_DIGITS; j++)
            begin
                if (bcd_next[j*4 +: 4] >= 4'd5)
                begin
                    bcd_next[j*4 +: 4] = bcd_next[j*4 +: 4] + 4'd3;
                end
            end
            {bcd_next, shift_next} = {bcd_next[itoa_pkg::BCD_W-2:0], shift_next, 1'b0};
        end
    end

    // index of the most significant nonzero digit, zero if none
    always_comb
    begin
        top_next = '0;
        for (int j = 0; j < itoa_pkg::DEC_DIGITS; j++)
        begin
            if (bcd_reg[j*4 +: 4] != 4'd0)
            begin
                top_next = IDX_W'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_SIGN;
            item_reg      <= '0;
            shift_reg     <= '0;
            bcd_reg       <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        item_reg <= q_item;
                        step_reg <= '0;
                        if (q_item.hex)
                        begin
                            bcd_reg   <= {{(itoa_pkg::BCD_W - itoa_pkg::VALUE_W){1'b0}},
                                          q_item.mag};
                            state_reg <= S_COUNT;
                        end
                        else
                        begin
                            bcd_reg   <= '0;
                            shift_reg <= q_item.mag;
                            state_reg <= S_CONV;
                        end
                    end
                end
                S_CONV:
                begin
                    bcd_reg   <= bcd_next;
                    shift_reg <= shift_next;
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_COUNT;
                    end
                end
                S_COUNT:
                begin
                    idx_reg   <= top_next;
                    phase_reg <= item_reg.neg ? P_SIGN : (item_reg.hex ? P_ZERO : P_DIG);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        case (phase_reg)
                            P_SIGN:
                            begin
                                char_reg  <= itoa_pkg::CH_MINUS;
                                last_reg  <= 1'b0;
                                phase_reg <= item_reg.hex ? P_ZERO : P_DIG;
                            end
                            P_ZERO:
                            begin
                                char_reg  <= itoa_pkg::CH_ZERO;
                                last_reg  <= 1'b0;
                                phase_reg <= P_X;
                            end
                            P_X:
                            begin
                                char_reg  <= item_reg.upper ? itoa_pkg::CH_X_UP
                                                            : itoa_pkg::CH_X_LO;
                                last_reg  <= 1'b0;
                                phase_reg <= P_DIG;
                            end
                            P_DIG:
                            begin
                                char_reg <= itoa_pkg::digit_char(cur_digit, item_reg.upper);
                                if (idx_reg == '0)
                                begin
                                    if (item_reg.hex)
                                    begin
                                        last_reg  <= 1'b1;
                                        state_reg <= S_IDLE;
                                    end
                                    else
                                    begin
                                        last_reg  <= 1'b0;
                                        phase_reg <= P_L1;
                                    end
                                end
                                else
                                begin
                                    last_reg <= 1'b0;
                                    idx_reg  <= idx_reg - 1'b1;
                                end
                            end
                            P_L1:
                            begin
                                char_reg  <= itoa_pkg::CH_L;
                                last_reg  <= 1'b0;
                                phase_reg <= P_L2;
                            end
                            P_L2:
                            begin
                                char_reg  <= itoa_pkg::CH_L;
                                last_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            default:
                            begin
                                char_reg  <= itoa_pkg::CH_L;
                                last_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/int64_to_ascii_formatter.sv =====
// int64_to_ascii_formatter: top level; front, request queue and back end.
// Depends on itoa_pkg, itoa_front, itoa_fifo, itoa_back.
//
// Formats a signed 64-bit value as ASCII text, one character per output request, most
// significant first, with last set on the final character: decimal as [-]digits"ll", hex as
// [-]0x/0X digits. The back end fetches a request from the queue, then, in decimal mode only,
// runs shift-add-3 conversion (4 bits per cycle), then finds the leading digit and emits one
// character per cycle while out_ready is high. The queue of QUEUE_DEPTH requests lets the
// input side keep accepting while the back end works.
module int64_to_ascii_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [63:0] value,
    input  logic               radix_hex,
    input  logic               upper_case,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         character,
    output logic               last
);

    itoa_pkg::itoa_item_t push_item;
    itoa_pkg::itoa_item_t pop_item;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_push;
    logic                 q_pop;

    itoa_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .radix_hex  (radix_hex),
        .upper_case (upper_case),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    itoa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (push_item),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (pop_item)
    );

    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

// ===== sv/itoa_checker.sv =====
// itoa_checker: port-level assertions for int64_to_ascii_formatter, attached by bind.
// Depends on itoa_pkg for character codes.
module itoa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] character,
    input logic       last
);

    logic is_digit;
    logic is_hex_letter;

    assign is_digit      = (character >= 8'h30) && (character <= 8'h39);
    assign is_hex_letter = ((character >= 8'h41) && (character <= 8'h46))
                        || ((character >= 8'h61) && (character <= 8'h66));

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
        else $error("output request changed while stalled");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_digit || is_hex_letter || (character == itoa_pkg::CH_MINUS)
                   || (character == itoa_pkg::CH_X_LO) || (character == itoa_pkg::CH_X_UP)
                   || (character == itoa_pkg::CH_L))
        else $error("character outside the output alphabet");

    a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> is_digit || is_hex_letter || (character == itoa_pkg::CH_L))
        else $error("text ends on a sign or prefix");

    a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((character == itoa_pkg::CH_MINUS) || (character == itoa_pkg::CH_X_LO)
                   || (character == itoa_pkg::CH_X_UP)) |-> !last)
        else $error("sign or prefix flagged last");

endmodule

bind int64_to_ascii_formatter itoa_checker u_itoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
);

// ===== test/tb_top.sv =====
// tb_top: testbench for int64_to_ascii_formatter; formats 64-bit numbers as decimal or hex text.
// Checks every output character and its last flag against an in-bench formatter.
// Depends only on the RTL (int64_to_ascii_formatter and its itoa_pkg).
`timescale 1ns / 100ps

module tb_top;

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          HOLD_AFTER  = 60;
    localparam int          MAX_WAIT    = 12;
    localparam int          N_RANDOM    = 260;
    localparam logic [63:0] MOST_NEG    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  ASC_ZERO    = "0";
    localparam logic [7:0]  ASC_A_LO    = "a";
    localparam logic [7:0]  ASC_A_UP    = "A";
    localparam logic [7:0]  ASC_MINUS   = "-";
    localparam logic [7:0]  ASC_X_LO    = "x";
    localparam logic [7:0]  ASC_X_UP    = "X";
    localparam logic [7:0]  ASC_L       = "l";

    typedef struct {
        logic signed [63:0] num;
        logic               hex;
        logic               up;
        logic               calm;
    } fmt_request_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } text_char_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic signed [63:0] value      = '0;
    logic               radix_hex  = 1'b0;
    logic               upper_case = 1'b0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [7:0]         character;
    logic               last;

    fmt_request_t pending_requests[$];
    text_char_t   expected_text[$];
    fmt_request_t next_req;
    text_char_t   want;

    int send_gap       = 0;
    int recv_gap       = 0;
    int recv_draw      = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int requests_taken = 0;
    int chars_checked  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int n_dec          = 0;
    int n_hex          = 0;
    int n_neg          = 0;
    int longest_text   = 0;

    int64_to_ascii_formatter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .radix_hex  (radix_hex),
        .upper_case (upper_case),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic up);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = ASC_ZERO + 8'(d);
        end
        else
        begin
            c = (up ? ASC_A_UP : ASC_A_LO) + 8'(d) - 8'd10;
        end
        return c;
    endfunction

    // Appends the expected text of one request to expected_text.
    function automatic void format_number(input logic signed [63:0] v, input logic hex,
                                          input logic up);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [7:0]  rev[20];
        logic [7:0]  text[$];
        text_char_t  tc;
        int          nd;
        mag   = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        radix = hex ? 64'd16 : 64'd10;
        nd    = 0;
        do
        begin
            rev[nd] = digit_ascii(4'(mag % radix), up);
            nd++;
            mag = mag / radix;
        end
        while (mag != 0);
        if (v[63])
        begin
            text.push_back(ASC_MINUS);
        end
        if (hex)
        begin
            text.push_back(ASC_ZERO);
            text.push_back(up ? ASC_X_UP : ASC_X_LO);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            text.push_back(rev[i]);
        end
        if (!hex)
        begin
            text.push_back(ASC_L);
            text.push_back(ASC_L);
        end
        for (int i = 0; i < text.size(); i++)
        begin
            tc.ch  = text[i];
            tc.fin = (i == text.size() - 1);
            expected_text.push_back(tc);
        end
        if (hex)
        begin
            n_hex++;
        end
        else
        begin
            n_dec++;
        end
        if (v[63])
        begin
            n_neg++;
        end
        if (text.size() > longest_text)
        begin
            longest_text = text.size();
        end
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp_v);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, exp_v);
        mismatch_count++;
    endtask

    task automatic add_request(input logic signed [63:0] v, input logic hex, input logic up,
                               input logic calm);
        fmt_request_t r;
        r.num  = v;
        r.hex  = hex;
        r.up   = up;
        r.calm = calm;
        pending_requests.push_back(r);
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                format_number(value, radix_hex, upper_case);
                requests_taken <= requests_taken + 1;
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    value      <= next_req.num;
                    radix_hex  <= next_req.hex;
                    upper_case <= next_req.up;
                    in_valid   <= 1'b1;
                    send_gap   <= next_req.calm ? 0 : $urandom_range(0, MAX_WAIT);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the request queue fills and in_ready drops
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && requests_taken == HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                begin
                    report("unexpected character", character, 8'h00);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.ch)
                    begin
                        report("character", character, want.ch);
                    end
                    if (last !== want.fin)
                    begin
                        report("last", 8'(last), 8'(want.fin));
                    end
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                recv_draw = ((chars_checked / 400) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
                if (recv_draw == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    recv_gap  <= recv_draw;
                end
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= (recv_gap == 1);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[%0t] timeout, %0d characters still expected", $time,
                     expected_text.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [63:0] v;
        logic [63:0] p;
        int          kind;
        int          k;
        int          total_requests;

        // directed: zero, unit, extremes, both radixes and cases
        add_request(64'sd0, 1'b0, 1'b0, 1'b0);
        add_request(64'sd0, 1'b1, 1'b0, 1'b0);
        add_request(64'sd0, 1'b1, 1'b1, 1'b0);
        add_request(64'sd1, 1'b0, 1'b1, 1'b0);
        add_request(-64'sd1, 1'b0, 1'b0, 1'b0);
        add_request(-64'sd1, 1'b1, 1'b1, 1'b0);
        add_request(MOST_POS, 1'b0, 1'b0, 1'b0);
        add_request(MOST_POS, 1'b1, 1'b1, 1'b0);
        add_request(MOST_POS, 1'b1, 1'b0, 1'b0);
        add_request(MOST_NEG, 1'b0, 1'b0, 1'b0);
        add_request(MOST_NEG, 1'b0, 1'b1, 1'b0);
        add_request(MOST_NEG, 1'b1, 1'b0, 1'b0);
        add_request(MOST_NEG, 1'b1, 1'b1, 1'b0);
        add_request(64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 1'b0);
        add_request(64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 1'b0);
        add_request(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 1'b0);
        add_request(64'sd1000000000000000000, 1'b0, 1'b0, 1'b0);
        add_request(64'sd999999999999999999, 1'b0, 1'b1, 1'b0);
        add_request(-64'sd10, 1'b0, 1'b0, 1'b0);
        add_request(64'sd15, 1'b1, 1'b0, 1'b0);
        add_request(64'sd16, 1'b1, 1'b1, 1'b0);
        add_request(64'sd9, 1'b0, 1'b0, 1'b0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3:
                begin
                    v = {$urandom, $urandom};
                end
                4, 5:
                begin
                    v = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
                6:
                begin
                    v = 64'($urandom_range(0, 1000));
                end
                7:
                begin
                    k = $urandom_range(0, 18);
                    p = 64'd1;
                    for (int j = 0; j < k; j++)
                    begin
                        p = p * 64'd10;
                    end
                    v = p + 64'($urandom_range(0, 2)) - 64'd1;
                end
                8:
                begin
                    case ($urandom_range(0, 3))
                        0: v = MOST_NEG;
                        1: v = MOST_POS;
                        2: v = '1;
                        default: v = '0;
                    endcase
                end
                default:
                begin
                    v = (64'd1 << (4 * $urandom_range(0, 15))) + 64'($urandom_range(0, 2))
                        - 64'd1;
                end
            endcase
            if (kind >= 4 && kind != 8 && $urandom_range(0, 1) == 1)
            begin
                v = 64'd0 - v;
            end
            add_request(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        ((i / 40) % 3) == 2);
        end
        total_requests = pending_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_taken < total_requests)
        begin
            @(posedge clk);
        end
        while (expected_text.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        $display("run covered %0d numbers: %0d decimal, %0d hex, %0d negative",
                 requests_taken, n_dec, n_hex, n_neg);
        $display("%0d characters checked, longest text %0d characters",
                 chars_checked, longest_text);
        if (mismatch_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/itoa_pkg.sv
sv/itoa_front.sv
sv/itoa_fifo.sv
sv/itoa_back.sv
sv/int64_to_ascii_formatter.sv
sv/itoa_checker.sv
test/tb_top.sv
